>>> src/mcpd_pkg.sv
package mcpd_pkg;

  // default geometry
  localparam int NUM_QUEUES_DEF  = 20;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int TAG_BITS_DEF    = 16;

  // fixed port widths
  localparam int IDX_W = 6;
  localparam int TAG_W = 16;

  // token field widths, sized for the largest queue depth supported (256)
  localparam int SLOT_W = 8;
  localparam int FILL_W = 9;

  // request kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TAKE = 1'b1;

  typedef enum logic [2:0] {
    OUT_ADDED     = 3'd0,
    OUT_FULL      = 3'd1,
    OUT_SERVED    = 3'd2,
    OUT_EMPTY     = 3'd3,
    OUT_BAD_INDEX = 3'd4
  } outcome_t;

  // request travelling down the queue cells; the owning cell fills in the answer
  typedef struct packed {
    logic              valid;
    logic              kind;
    logic              urgent;
    logic [IDX_W-1:0]  qidx;
    logic              hit;
    outcome_t          outcome;
    logic [SLOT_W-1:0] slot;
    logic [FILL_W-1:0] fill;
  } tok_t;

endpackage

>>> src/mcpd_ram.sv
module mcpd_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/mcpd_cell.sv
module mcpd_cell #(
  parameter int QUEUE_DEPTH = mcpd_pkg::QUEUE_DEPTH_DEF,
  parameter int CELL_ID     = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mcpd_pkg::tok_t tok_i,
  output mcpd_pkg::tok_t tok_o
);

  localparam int HW   = $clog2(QUEUE_DEPTH);
  localparam int FW   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW = HW + 1;
  localparam int IW   = mcpd_pkg::IDX_W;
  localparam int SLW  = mcpd_pkg::SLOT_W;
  localparam int FLW  = mcpd_pkg::FILL_W;
  localparam logic [IW-1:0] MY_ID = IW'(CELL_ID);

  logic [HW-1:0]   head_r, head_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  mcpd_pkg::tok_t  tok_r, tok_nxt;

  logic            hit, full, empty;
  logic [HW-1:0]   head_inc, head_dec, tail;
  logic [SUMW-1:0] tail_sum;

  assign hit   = tok_i.valid && (tok_i.qidx == MY_ID);
  assign full  = (fill_r == FW'(QUEUE_DEPTH));
  assign empty = (fill_r == '0);

  assign head_inc = (head_r == HW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? HW'(QUEUE_DEPTH - 1) : head_r - 1'b1;

  // head + fill stays below twice the depth when not full
  assign tail_sum = SUMW'(head_r) + SUMW'(fill_r);
  assign tail     = (tail_sum >= SUMW'(QUEUE_DEPTH)) ?
                    HW'(tail_sum - SUMW'(QUEUE_DEPTH)) : HW'(tail_sum);

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    tok_nxt  = tok_i;
    if (hit) begin
      tok_nxt.hit = 1'b1;
      priority if (tok_i.kind == mcpd_pkg::KIND_ADD && full) begin
        tok_nxt.outcome = mcpd_pkg::OUT_FULL;
        tok_nxt.fill    = FLW'(fill_r);
      end else if (tok_i.kind == mcpd_pkg::KIND_ADD) begin
        fill_nxt        = fill_r + 1'b1;
        tok_nxt.outcome = mcpd_pkg::OUT_ADDED;
        tok_nxt.fill    = FLW'(fill_nxt);
        if (tok_i.urgent) begin
          head_nxt     = head_dec;
          tok_nxt.slot = SLW'(head_dec);
        end else begin
          tok_nxt.slot = SLW'(tail);
        end
      end else if (empty) begin
        tok_nxt.outcome = mcpd_pkg::OUT_EMPTY;
        tok_nxt.fill    = '0;
      end else begin
        fill_nxt        = fill_r - 1'b1;
        head_nxt        = head_inc;
        tok_nxt.outcome = mcpd_pkg::OUT_SERVED;
        tok_nxt.slot    = SLW'(head_r);
        tok_nxt.fill    = FLW'(fill_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      tok_r  <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

>>> src/multi_class_priority_deque.sv
// Set of NUM_QUEUES bounded queues of QUEUE_DEPTH entries each. A transaction
// is taken when start is high and busy is low; busy then stays high until its
// result has been shown. Every transaction gives exactly one result, shown for
// one cycle with out_valid high; there is no back-pressure, so the receiver
// must capture it in that cycle. The result strobe comes once the request has
// passed the injection register, the row of queue cells, which the request
// walks one cell per cycle, and a single access to the shared entry RAM with
// registered read data. Busy is still high while the strobe is shown and
// drops after it, so a new transaction is only taken once the last result
// has been shown. The entry RAM needs no clearing after reset: only slots
// inside a queue's occupied region are ever served from it.
module multi_class_priority_deque #(
  parameter int NUM_QUEUES  = mcpd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mcpd_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = mcpd_pkg::TAG_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command side
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_kind,
  input  logic [mcpd_pkg::IDX_W-1:0]           in_queue_index,
  input  logic [mcpd_pkg::TAG_W-1:0]           in_item_tag,
  input  logic                                 in_urgent,
  // result side
  output logic                                 out_valid,
  output logic [2:0]                           out_outcome,
  output logic [mcpd_pkg::TAG_W-1:0]           out_served_tag,
  output logic                                 out_served_urgent,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0]   out_queue_fill
);

  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int SW = TAG_BITS + 1;           // urgent bit sits above the tag
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // Transaction capture
  // ---------------------------------------------------------------------------
  logic                          acc;
  logic                          busy_r, busy_nxt;
  mcpd_pkg::tok_t                inj_r, inj_nxt;
  logic [mcpd_pkg::TAG_W-1:0]    tag_r;
  logic                          urgent_r;

  assign acc = start && !busy_r;

  always_comb begin
    inj_nxt         = '0;
    inj_nxt.outcome = mcpd_pkg::OUT_BAD_INDEX;  // stands unless a cell claims it
    if (acc) begin
      inj_nxt.valid  = 1'b1;
      inj_nxt.kind   = in_kind;
      inj_nxt.urgent = in_urgent;
      inj_nxt.qidx   = in_queue_index;
    end
  end

  // payload for the RAM write, held for the life of the transaction
  always_ff @(posedge clk) begin
    if (acc) begin
      tag_r    <= in_item_tag;
      urgent_r <= in_urgent;
    end
  end

  // ---------------------------------------------------------------------------
  // Row of queue cells: each owns one queue's head pointer and fill count.
  // The request moves one cell per cycle; the matching cell updates its state
  // and writes outcome, fill and (on an add or a serve) slot into the token.
  // ---------------------------------------------------------------------------
  mcpd_pkg::tok_t chain [NUM_QUEUES + 1];
  logic [NUM_QUEUES:0] chain_vld;

  assign chain[0] = inj_r;

  for (genvar i = 0; i < NUM_QUEUES; i++) begin : g_cell
    mcpd_cell #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .CELL_ID     (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (chain[i]),
      .tok_o (chain[i + 1])
    );
  end

  for (genvar i = 0; i <= NUM_QUEUES; i++) begin : g_vld
    assign chain_vld[i] = chain[i].valid;
  end

  // ---------------------------------------------------------------------------
  // Entry RAM access at the end of the row
  // ---------------------------------------------------------------------------
  mcpd_pkg::tok_t       te;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [SW-1:0]        ram_wdata, ram_rdata;
  logic [63:0]          tag_wide;
  logic [63:0]          rd_tag_wide;

  assign te       = chain[NUM_QUEUES];
  assign ram_we   = te.valid && te.hit && (te.outcome == mcpd_pkg::OUT_ADDED);
  assign ram_addr = AW'(32'(te.qidx) * 32'(QUEUE_DEPTH) + 32'(te.slot));

  // only the low TAG_BITS bits of a tag are kept
  assign tag_wide  = 64'(tag_r);
  assign ram_wdata = {urgent_r, tag_wide[TAG_BITS-1:0]};

  mcpd_ram #(
    .WIDTH (SW),
    .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result register: lines up with the registered RAM read data
  // ---------------------------------------------------------------------------
  logic                pend_valid_r;
  mcpd_pkg::outcome_t  pend_outcome_r;
  logic [FW-1:0]       pend_fill_r;
  logic                served;

  always_ff @(posedge clk) begin
    if (te.valid) begin
      pend_outcome_r <= te.hit ? te.outcome : mcpd_pkg::OUT_BAD_INDEX;
      pend_fill_r    <= te.hit ? FW'(te.fill) : '0;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    priority if (acc) begin
      busy_nxt = 1'b1;
    end else if (pend_valid_r) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      inj_r        <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      inj_r        <= inj_nxt;
      pend_valid_r <= te.valid;
    end
  end

  assign served      = (pend_outcome_r == mcpd_pkg::OUT_SERVED);
  assign rd_tag_wide = 64'(ram_rdata[TAG_BITS-1:0]);

  assign busy              = busy_r;
  assign out_valid         = pend_valid_r;
  assign out_outcome       = pend_outcome_r;
  assign out_served_tag    = served ? rd_tag_wide[mcpd_pkg::TAG_W-1:0] : '0;
  assign out_served_urgent = served ? ram_rdata[TAG_BITS] : 1'b0;
  assign out_queue_fill    = pend_fill_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // at most one transaction in flight anywhere in the row or result stage
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({chain_vld, pend_valid_r}))
    else $error("more than one transaction in flight");

  // a result is only ever shown for an accepted transaction
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result shown while idle");

  // busy drops right after the result, so each transaction gives one result
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy_r && !out_valid)
    else $error("busy held or result repeated");

  // a token that no cell claimed reports a bad index with empty fields
  a_bad_index_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome == mcpd_pkg::OUT_BAD_INDEX) |->
      (out_queue_fill == '0 && out_served_tag == '0 && !out_served_urgent))
    else $error("bad index result carries data");

endmodule

>>> test/multi_class_priority_deque_tb.sv
// Self-checking bench for the multi-class priority deque.
// A short directed table runs first, then a long random run. Both feed an
// in-bench model of the queues. Every result strobe is checked against the
// oldest pending answer.
module multi_class_priority_deque_tb;
  import mcpd_pkg::*;

  localparam int NQ        = NUM_QUEUES_DEF;
  localparam int QD        = QUEUE_DEPTH_DEF;
  localparam int TB_BITS   = TAG_BITS_DEF;
  localparam int FILL_BITS = $clog2(QD + 1);

  localparam int DRAIN_CYCLES = NQ + 8;
  // cycles with neither an accepted transaction nor a result; the slowest
  // correct gap is a full service time plus the longest sender hold-off
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1350;

  // directed rows: answer either typed in here or taken from the model
  localparam logic TYPED = 1'b1;
  localparam logic MODEL = 1'b0;

  typedef struct packed {
    outcome_t             outcome;
    logic [TAG_W-1:0]     tag;
    logic                 urg;
    logic [FILL_BITS-1:0] fill;
  } answer_t;

  typedef struct packed {
    logic                 kind;
    logic [IDX_W-1:0]     q;
    logic [TAG_W-1:0]     tag;
    logic                 urg;
    logic                 typed;
    outcome_t             e_out;
    logic [FILL_BITS-1:0] e_fill;
  } step_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_kind;
  logic [IDX_W-1:0]     in_queue_index;
  logic [TAG_W-1:0]     in_item_tag;
  logic                 in_urgent;
  logic                 out_valid;
  logic [2:0]           out_outcome;
  logic [TAG_W-1:0]     out_served_tag;
  logic                 out_served_urgent;
  logic [FILL_BITS-1:0] out_queue_fill;

  multi_class_priority_deque DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_queue_index    (in_queue_index),
    .in_item_tag       (in_item_tag),
    .in_urgent         (in_urgent),
    .out_valid         (out_valid),
    .out_outcome       (out_outcome),
    .out_served_tag    (out_served_tag),
    .out_served_urgent (out_served_urgent),
    .out_queue_fill    (out_queue_fill)
  );

  // Model of the queues: one circular buffer per class with head and count.
  logic [TB_BITS:0] slot_words [NQ][QD];
  int               head_slot  [NQ];
  int               held_count [NQ];

  answer_t pending_answers [$];
  answer_t oldest;
  int      errors;
  int      idle_cycles;

  // Directed table. Typed rows are the ones readable at a glance: empty
  // queues, straight after reset and once drained, bad indexes and a full queue. The rest
  // (plain adds, urgent adds, serves and the head wrapping below slot 0)
  // are left to the model.
  step_row_t directed_rows [0:25] = '{
    '{KIND_TAKE, 6'd0,  16'h0000, 1'b0, TYPED, OUT_EMPTY,     4'd0},
    '{KIND_TAKE, 6'd19, 16'h0000, 1'b1, TYPED, OUT_EMPTY,     4'd0},
    '{KIND_ADD,  6'd20, 16'h1234, 1'b1, TYPED, OUT_BAD_INDEX, 4'd0},
    '{KIND_TAKE, 6'd63, 16'hffff, 1'b0, TYPED, OUT_BAD_INDEX, 4'd0},
    '{KIND_ADD,  6'd63, 16'hffff, 1'b0, TYPED, OUT_BAD_INDEX, 4'd0},
    '{KIND_ADD,  6'd0,  16'h0000, 1'b0, MODEL, OUT_ADDED,     4'd0},
    '{KIND_ADD,  6'd0,  16'hffff, 1'b1, MODEL, OUT_ADDED,     4'd0},
    '{KIND_TAKE, 6'd0,  16'h5555, 1'b1, MODEL, OUT_ADDED,     4'd0},
    '{KIND_TAKE, 6'd0,  16'haaaa, 1'b0, MODEL, OUT_ADDED,     4'd0},
    '{KIND_TAKE, 6'd0,  16'h0000, 1'b0, TYPED, OUT_EMPTY,     4'd0},
    '{KIND_ADD,  6'd19, 16'h0001, 1'b0, MODEL, OUT_ADDED,     4'd0},
    '{KIND_ADD,  6'd19, 16'h8000, 1'b1, MODEL, OUT_ADDED,     4'd0},
    '{KIND_ADD,  6'd19, 16'h00ff, 1'b0, MODEL, OUT_ADDED,     4'd0},
    '{KIND_ADD,  6'd19, 16'hff00, 1'b1, MODEL, OUT_ADDED,     4'd0},
    '{KIND_ADD,  6'd19, 16'h0f0f, 1'b0, MODEL, OUT_ADDED,     4'd0},
    '{KIND_ADD,  6'd19, 16'hf0f0, 1'b1, MODEL, OUT_ADDED,     4'd0},
    '{KIND_ADD,  6'd19, 16'h3c3c, 1'b0, MODEL, OUT_ADDED,     4'd0},
    '{KIND_ADD,  6'd19, 16'hc3c3, 1'b1, MODEL, OUT_ADDED,     4'd0},
    '{KIND_ADD,  6'd19, 16'h7777, 1'b0, TYPED, OUT_FULL,      4'd8},
    '{KIND_ADD,  6'd19, 16'hffff, 1'b1, TYPED, OUT_FULL,      4'd8},
    '{KIND_TAKE, 6'd19, 16'h0000, 1'b0, MODEL, OUT_ADDED,     4'd0},
    '{KIND_TAKE, 6'd19, 16'h0000, 1'b0, MODEL, OUT_ADDED,     4'd0},
    '{KIND_TAKE, 6'd19, 16'h0000, 1'b0, MODEL, OUT_ADDED,     4'd0},
    '{KIND_ADD,  6'd19, 16'hbeef, 1'b1, MODEL, OUT_ADDED,     4'd0},
    '{KIND_TAKE, 6'd19, 16'h0000, 1'b0, MODEL, OUT_ADDED,     4'd0},
    '{KIND_ADD,  6'd1,  16'h0000, 1'b1, MODEL, OUT_ADDED,     4'd0}
  };

  // Apply one transaction to the queue model and return the answer it gives.
  function automatic answer_t apply_to_queues(input logic kind, input logic [IDX_W-1:0] q,
                                               input logic [TAG_W-1:0] tag, input logic urg);
    answer_t          ans;
    int               qi;
    int               slot;
    logic [TB_BITS:0] word;
    ans = '0;
    qi  = int'(q);
    if (qi >= NQ) begin
      ans.outcome = OUT_BAD_INDEX;
    end else if (kind == KIND_ADD) begin
      if (held_count[qi] >= QD) begin
        ans.outcome = OUT_FULL;
        ans.fill    = FILL_BITS'(held_count[qi]);
      end else begin
        word = {urg, tag[TB_BITS-1:0]};
        if (urg) begin
          // urgent: step the head back one slot and write there
          head_slot[qi] = (head_slot[qi] + QD - 1) % QD;
          slot = head_slot[qi];
        end else begin
          slot = (head_slot[qi] + held_count[qi]) % QD;
        end
        slot_words[qi][slot] = word;
        held_count[qi]++;
        ans.outcome = OUT_ADDED;
        ans.fill    = FILL_BITS'(held_count[qi]);
      end
    end else if (held_count[qi] == 0) begin
      ans.outcome = OUT_EMPTY;
    end else begin
      word = slot_words[qi][head_slot[qi]];
      head_slot[qi] = (head_slot[qi] + 1) % QD;
      held_count[qi]--;
      ans.outcome          = OUT_SERVED;
      ans.tag[TB_BITS-1:0] = word[TB_BITS-1:0];
      ans.urg              = word[TB_BITS];
      ans.fill             = FILL_BITS'(held_count[qi]);
    end
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Present one transaction from a falling edge and hold it until the block
  // takes it. An optional random hold-off beforehand lets start rise at any
  // point of the busy window, or well after it has ended.
  task automatic issue_request(input logic kind, input logic [IDX_W-1:0] q,
                               input logic [TAG_W-1:0] tag, input logic urg,
                               input bit hold_off, input bit typed, input answer_t typed_ans);
    answer_t predicted;
    int      gap;
    if (hold_off && $urandom_range(0, 99) < 35) begin
      gap = $urandom_range(1, 30);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          <= 1'b1;
    in_kind        <= kind;
    in_queue_index <= q;
    in_item_tag    <= tag;
    in_urgent      <= urg;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge: the model moves on now
    predicted = apply_to_queues(kind, q, tag, urg);
    pending_answers.push_back(typed ? typed_ans : predicted);
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: no back-pressure, so every strobe is checked on the spot.
  // The watchdog sits here too, counting cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("result with no transaction pending, outcome", out_outcome, -1);
        end else begin
          oldest = pending_answers.pop_front();
          if (out_outcome !== oldest.outcome)
            report_mismatch("outcome", out_outcome, oldest.outcome);
          if (out_served_tag !== oldest.tag)
            report_mismatch("served_tag", out_served_tag, oldest.tag);
          if (out_served_urgent !== oldest.urg)
            report_mismatch("served_urgent", out_served_urgent, oldest.urg);
          if (out_queue_fill !== oldest.fill)
            report_mismatch("queue_fill", out_queue_fill, oldest.fill);
        end
      end
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    answer_t          typed_ans;
    step_row_t        row;
    logic             kind;
    logic [IDX_W-1:0] q;
    int               focus;
    int               add_bias;
    int               pick;
    bit               quiet;
    focus          = 0;
    add_bias       = 50;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_kind        = KIND_ADD;
    in_queue_index = '0;
    in_item_tag    = '0;
    in_urgent      = 1'b0;
    for (int i = 0; i < NQ; i++) begin
      head_slot[i]  = 0;
      held_count[i] = 0;
      for (int j = 0; j < QD; j++) slot_words[i][j] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < $size(directed_rows); i++) begin
      row               = directed_rows[i];
      typed_ans         = '0;
      typed_ans.outcome = row.e_out;
      typed_ans.fill    = row.e_fill;
      issue_request(row.kind, row.q, row.tag, row.urg, 1'b1, row.typed, typed_ans);
    end

    // Random run. Traffic mostly hammers one focus queue so that queues fill
    // up, hit full and wrap; the add/take balance shifts every 60 transactions
    // so queues both drain to empty and sit at full. A few bad indexes are
    // mixed in. Transactions 500..799 go back to back with no hold-off.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) focus = $urandom_range(0, NQ - 1);
      if (i % 60 == 0) add_bias = 25 + 25 * $urandom_range(0, 2);
      pick = $urandom_range(0, 99);
      if (pick < 6)       q = IDX_W'($urandom_range(NQ, 63));
      else if (pick < 70) q = IDX_W'(focus);
      else                q = IDX_W'($urandom_range(0, NQ - 1));
      kind  = ($urandom_range(0, 99) < add_bias) ? KIND_ADD : KIND_TAKE;
      quiet = (i >= 500 && i < 800);
      issue_request(kind, q, TAG_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                    !quiet, MODEL, '0);
    end
    start <= 1'b0;

    // drain: the watchdog catches a result that never comes
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mcpd_pkg.sv
src/mcpd_ram.sv
src/mcpd_cell.sv
src/multi_class_priority_deque.sv
test/multi_class_priority_deque_tb.sv
